>>> hw/rtl/twpc_pkg.sv
// Package for the two-way page cache policy controller.
// Holds the action and status codes, the sequencer states and the result item type.
// Depends on nothing; used by two_way_page_cache_policy.
package twpc_pkg;

    // Width of a page number field on the ports.
    localparam int PAGE_W = 20;

    typedef enum logic [1:0] {
        ACT_ACCESS = 2'd0,
        ACT_MARK   = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_HIT       = 3'd0,
        STAT_MISS      = 3'd1,
        STAT_MARKED    = 3'd2,
        STAT_NOT_CACHED = 3'd3,
        STAT_RANGE     = 3'd4,
        STAT_FLUSH_WB  = 3'd5,
        STAT_NOTHING   = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_REM,
        S_RD0,
        S_RD1,
        S_CMP,
        S_EMIT,
        S_FL_SCAN,
        S_FL_READ,
        S_FL_END
    } t_state;

    typedef struct packed {
        t_status            status;
        logic               way;
        logic               wb;
        logic [PAGE_W-1:0]  wb_page;
        logic               wb_store;
        logic               last;
    } t_result;

endpackage

>>> hw/rtl/twpc_ram.sv
// Generic memory with one write port and one registered read port.
// Holds the page tags of the cache controller; no package dependencies.
module twpc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/two_way_page_cache_policy.sv
// Top level of the two-way page cache policy controller (tags, valid, dirty, LRU).
// Depends on twpc_pkg for codes and types and on twpc_ram for the tag memory.
//
//  Channel  Dir  Signals                      Contents
//  s_axis   in   tvalid tready tdata tuser    request: action, store, page, page count
//  m_axis   out  tvalid tready tdata tlast    result: status, way, writeback fields
//
// An access or mark-dirty keeps the input off from its accepting edge until it emits:
// the set index is found (a reciprocal multiply for the quotient, then a multiply-back,
// subtract and one correcting subtract), the set's tags are read one per cycle through
// the single read port of the tag memory, then it compares and updates, then emits.
// An out-of-range request goes straight to emit. A flush walks all 4 * SET_COUNT
// blocks, one per cycle unless a held result stalls, with a read state per dirty block and an end state.
// Reset is synchronous and active low; it clears valid, dirty and LRU bits at once, while
// the tag memory is left as it is. A stalled output holds the sequencer where it emits.
module two_way_page_cache_policy #(
    parameter int SET_COUNT        = 16,
    parameter int PAGE_NUMBER_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [19:0] page, [40:20] page_count, [47:41] zero
    input  logic [2:0]  i_s_tuser,   // [1:0] action, [2] which_store
    // Result channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [2:0] status, [3] way, [4] writeback,
                                     // [24:5] writeback_page, [25] writeback_store
    output logic        o_m_tlast    // last
);

    // Tag width: page numbers are masked to PAGE_NUMBER_BITS, and the port carries 20.
    localparam int TAG_W  = (PAGE_NUMBER_BITS < twpc_pkg::PAGE_W) ?
                            PAGE_NUMBER_BITS : twpc_pkg::PAGE_W;
    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int LINE_W = $clog2(2 * SET_COUNT);
    localparam int BLK_N  = 4 * SET_COUNT;
    localparam int ADDR_W = LINE_W + 1;
    // Set index by reciprocal multiplication. The quotient estimate
    // floor(page * M / 2^24), with M = floor(2^24 / SET_COUNT), is never high and at most
    // one low for a page below 2^20, so one compare and subtract finishes the remainder.
    localparam int REC_SH = 24;
    localparam int PROD_W = TAG_W + REC_SH;
    localparam logic [REC_SH:0] REC_M = (REC_SH + 1)'((64'd1 << REC_SH) / SET_COUNT);

    // Sequencer and item registers.
    twpc_pkg::t_state   r_state, n_state;
    twpc_pkg::t_action  r_action, n_action;
    logic               r_store, n_store;
    logic [TAG_W-1:0]   r_page, n_page;
    logic [SET_W-1:0]   r_rem, n_rem;
    logic [TAG_W-1:0]   r_quo, n_quo;
    logic [TAG_W-1:0]   r_tag0, n_tag0;
    logic               r_hit0, n_hit0;
    // Flush walk position: set, store, way.
    logic [SET_W-1:0]   r_fs, n_fs;
    logic               r_fst, n_fst;
    logic               r_fw, n_fw;
    // A flush result held back until it is known whether it is the last one.
    logic               r_have, n_have;
    twpc_pkg::t_result  r_res, n_res;
    // Output register.
    logic               r_out_valid;
    twpc_pkg::t_result  r_out;

    // Per-block and per-line marks.
    logic [BLK_N-1:0]       r_valid;
    logic [BLK_N-1:0]       r_dirty;
    logic [2*SET_COUNT-1:0] r_lru;

    // Strobes from the sequencer.
    logic               out_load;
    twpc_pkg::t_result  out_data;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [TAG_W-1:0]   ram_rdata;
    logic               lru_we;
    logic               lru_val;
    logic               dirty_set;
    logic               dirty_clr;
    logic [ADDR_W-1:0]  mark_addr;

    // Shared datapath pieces.
    logic               in_flush;
    logic [SET_W-1:0]   cur_set;
    logic               cur_store;
    logic [LINE_W-1:0]  line;
    logic               cur_w;
    logic               tag_eq;
    logic [PROD_W-1:0]  rec_prod;
    logic [TAG_W-1:0]   quo_est;
    logic [SET_W:0]     rem_try;
    logic               out_free;
    logic               acc;
    logic [TAG_W-1:0]   in_page;
    logic [20:0]        in_count;
    logic               walk_end;
    logic               vway;
    logic               hit1;
    logic               evict_wb;

    assign in_flush  = (r_state == twpc_pkg::S_FL_SCAN) ||
                       (r_state == twpc_pkg::S_FL_READ);
    assign cur_set   = in_flush ? r_fs : r_rem;
    assign cur_store = in_flush ? r_fst : r_store;
    // Line = store * SET_COUNT + set; the block address appends the way.
    assign line      = (cur_store ? LINE_W'(SET_COUNT) : LINE_W'(0)) + LINE_W'(cur_set);
    assign cur_w     = in_flush ? r_fw : (r_state == twpc_pkg::S_RD1);
    assign ram_raddr = {line, cur_w};
    assign tag_eq    = (ram_rdata == r_page);
    // Quotient estimate from the page, then the remainder estimate, which lies below
    // twice the set count and so is exact in the low SET_W + 1 bits.
    assign rec_prod  = PROD_W'(r_page) * PROD_W'(REC_M);
    assign quo_est   = TAG_W'(rec_prod >> REC_SH);
    assign rem_try   = (SET_W + 1)'(r_page) - (SET_W + 1)'(r_quo) * (SET_W + 1)'(SET_COUNT);
    assign out_free  = !r_out_valid || i_m_tready;
    assign acc       = i_s_tvalid && o_s_tready;
    assign in_page   = i_s_tdata[TAG_W-1:0];
    assign in_count  = i_s_tdata[40:20];
    assign walk_end  = (r_fs == SET_W'(SET_COUNT - 1)) && r_fst && r_fw;
    assign vway      = r_lru[line];
    assign hit1      = r_valid[{line, 1'b1}] && tag_eq;
    assign evict_wb  = r_valid[{line, vway}] && r_dirty[{line, vway}];

    assign o_s_tready = (r_state == twpc_pkg::S_IDLE) && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twpc_pkg::S_IDLE;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
        end
        r_action <= n_action;
        r_store  <= n_store;
        r_page   <= n_page;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_tag0   <= n_tag0;
        r_hit0   <= n_hit0;
        r_fs     <= n_fs;
        r_fst    <= n_fst;
        r_fw     <= n_fw;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_store   = r_store;
        n_page    = r_page;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_tag0    = r_tag0;
        n_hit0    = r_hit0;
        n_fs      = r_fs;
        n_fst     = r_fst;
        n_fw      = r_fw;
        n_have    = r_have;
        n_res     = r_res;
        out_load  = 1'b0;
        out_data  = r_res;
        ram_we    = 1'b0;
        ram_waddr = {line, vway};
        lru_we    = 1'b0;
        lru_val   = 1'b0;
        dirty_set = 1'b0;
        dirty_clr = 1'b0;
        mark_addr = ram_raddr;
        case (r_state)
            twpc_pkg::S_IDLE: begin
                if (acc) begin
                    n_action = twpc_pkg::t_action'(i_s_tuser[1:0]);
                    n_store  = i_s_tuser[2];
                    n_page   = in_page;
                    n_rem    = '0;
                    n_fs     = '0;
                    n_fst    = 1'b0;
                    n_fw     = 1'b0;
                    n_have   = 1'b0;
                    if (n_action == twpc_pkg::ACT_FLUSH) begin
                        n_state = twpc_pkg::S_FL_SCAN;
                    end else if (n_action == twpc_pkg::ACT_NONE) begin
                        n_state = twpc_pkg::S_IDLE;
                    end else if (21'(in_page) >= in_count) begin
                        n_res   = '{status: twpc_pkg::STAT_RANGE, wb_page: '0, default: 1'b0};
                        n_res.last = 1'b1;
                        n_state = twpc_pkg::S_EMIT;
                    end else begin
                        n_state = twpc_pkg::S_MOD;
                    end
                end
            end
            twpc_pkg::S_MOD: begin
                n_quo   = quo_est;
                n_state = twpc_pkg::S_REM;
            end
            twpc_pkg::S_REM: begin
                if (rem_try >= (SET_W + 1)'(SET_COUNT)) begin
                    n_rem = SET_W'(rem_try - (SET_W + 1)'(SET_COUNT));
                end else begin
                    n_rem = SET_W'(rem_try);
                end
                n_state = twpc_pkg::S_RD0;
            end
            twpc_pkg::S_RD0: begin
                n_state = twpc_pkg::S_RD1;
            end
            twpc_pkg::S_RD1: begin
                // Way 0's tag is on the read port now; way 1 is being read.
                n_tag0  = ram_rdata;
                n_hit0  = r_valid[{line, 1'b0}] && tag_eq;
                n_state = twpc_pkg::S_CMP;
            end
            twpc_pkg::S_CMP: begin
                n_state = twpc_pkg::S_EMIT;
                n_res   = '{status: twpc_pkg::STAT_HIT, wb_page: '0, default: 1'b0};
                n_res.last = 1'b1;
                if (r_hit0 || hit1) begin
                    n_res.way = !r_hit0;
                    mark_addr = {line, !r_hit0};
                    if (r_action == twpc_pkg::ACT_ACCESS) begin
                        lru_we  = 1'b1;
                        lru_val = r_hit0;
                    end else begin
                        dirty_set    = 1'b1;
                        n_res.status = twpc_pkg::STAT_MARKED;
                    end
                end else if (r_action == twpc_pkg::ACT_MARK) begin
                    n_res.status = twpc_pkg::STAT_NOT_CACHED;
                end else begin
                    // Miss: refill the LRU way, reporting its old page if it is dirty.
                    ram_we       = 1'b1;
                    lru_we       = 1'b1;
                    lru_val      = !vway;
                    n_res.status = twpc_pkg::STAT_MISS;
                    n_res.way    = vway;
                    n_res.wb     = evict_wb;
                    if (evict_wb) begin
                        n_res.wb_page  = twpc_pkg::PAGE_W'(vway ? ram_rdata : r_tag0);
                        n_res.wb_store = r_store;
                    end
                end
            end
            twpc_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = twpc_pkg::S_IDLE;
                end
            end
            twpc_pkg::S_FL_SCAN: begin
                if (r_valid[ram_raddr] && r_dirty[ram_raddr]) begin
                    n_state = twpc_pkg::S_FL_READ;
                end else if (walk_end) begin
                    n_state = twpc_pkg::S_FL_END;
                end else begin
                    n_fw = !r_fw;
                    if (r_fw) begin
                        n_fst = !r_fst;
                        if (r_fst) begin
                            n_fs = r_fs + SET_W'(1);
                        end
                    end
                end
            end
            twpc_pkg::S_FL_READ: begin
                // The held result goes out once a later dirty block is found, or at the end of the walk.
                if (!r_have || out_free) begin
                    out_load  = r_have;
                    dirty_clr = 1'b1;
                    n_have    = 1'b1;
                    n_res     = '{status: twpc_pkg::STAT_FLUSH_WB, wb_page: '0,
                                  default: 1'b0};
                    n_res.way      = r_fw;
                    n_res.wb       = 1'b1;
                    n_res.wb_page  = twpc_pkg::PAGE_W'(ram_rdata);
                    n_res.wb_store = r_fst;
                    if (walk_end) begin
                        n_state = twpc_pkg::S_FL_END;
                    end else begin
                        n_state = twpc_pkg::S_FL_SCAN;
                        n_fw    = !r_fw;
                        if (r_fw) begin
                            n_fst = !r_fst;
                            if (r_fst) begin
                                n_fs = r_fs + SET_W'(1);
                            end
                        end
                    end
                end
            end
            twpc_pkg::S_FL_END: begin
                if (!r_have) begin
                    n_res = '{status: twpc_pkg::STAT_NOTHING, wb_page: '0, default: 1'b0};
                end
                n_res.last = 1'b1;
                n_have     = 1'b0;
                n_state    = twpc_pkg::S_EMIT;
            end
            default: begin
                n_state = twpc_pkg::S_IDLE;
            end
        endcase
    end

    // Valid, dirty and LRU marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_lru   <= '0;
        end else begin
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
                r_dirty[ram_waddr] <= 1'b0;
            end
            if (dirty_set) begin
                r_dirty[mark_addr] <= 1'b1;
            end
            if (dirty_clr) begin
                r_dirty[mark_addr] <= 1'b0;
            end
            if (lru_we) begin
                r_lru[line] <= lru_val;
            end
        end
    end

    // Output register: a new item loads while the old one is taken or absent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= out_data;
        end
    end

    twpc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (BLK_N)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_page),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {6'd0, r_out.wb_store, r_out.wb_page, r_out.wb, r_out.way,
                         r_out.status};

    // A refilled block is valid from the next cycle on.
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(ram_waddr)])
        else $error("refilled block not marked valid");

    // Only flush writebacks can be followed by more results of the same request.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.status != twpc_pkg::STAT_FLUSH_WB) |-> o_m_tlast)
        else $error("non-flush result without last");

    // Writeback fields are zero whenever no writeback is reported.
    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_out.wb) |-> (r_out.wb_page == '0 && !r_out.wb_store))
        else $error("writeback fields set without writeback");

    // Any request other than the reserved action keeps the block busy afterwards.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_s_tuser[1:0] != twpc_pkg::ACT_NONE) |=> !o_s_tready)
        else $error("request accepted without going busy");

endmodule
